[hdl/mpc_pkg.sv]
package mpc_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 28;
    localparam int ITER_W  = 16;
    localparam int CNT_W   = ITER_W + 1;
    localparam int IDX_W   = 11;
    localparam int ZW      = COORD_W + 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

    localparam logic signed [COORD_W-1:0] RST_X_MIN  = -32'sd644245094;
    localparam logic signed [COORD_W-1:0] RST_X_STEP = 32'sd570950;
    localparam logic signed [COORD_W-1:0] RST_Y_MIN  = -32'sd256899789;
    localparam logic signed [COORD_W-1:0] RST_Y_STEP = 32'sd571602;
    localparam logic [ITER_W-1:0]         RST_MAX_ITER = 16'd100;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_col;
        logic [IDX_W-1:0] pixel_row;
    } t_pixel_req;

    typedef struct packed {
        logic [IDX_W-1:0] out_col;
        logic [IDX_W-1:0] out_row;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [CNT_W-1:0] iter_count;
    } t_pixel_rsp;

    typedef struct packed {
        logic [IDX_W-1:0]          col;
        logic [IDX_W-1:0]          row;
        logic signed [COORD_W-1:0] cr;
        logic signed [COORD_W-1:0] ci;
    } t_work;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] y_min;
        logic signed [COORD_W-1:0] y_step;
        logic [ITER_W-1:0]         max_iter;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_MUL_LO,
        S_MUL_HI,
        S_SQUARE,
        S_UPDATE,
        S_DIVIDE,
        S_FINISH
    } t_back_state;

endpackage

[hdl/mpc_front.sv]
module mpc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  mpc_pkg::t_pixel_req i_req,
    input  mpc_pkg::t_cfg       i_cfg,
    output logic                o_wr,
    input  logic                i_wr_full,
    output mpc_pkg::t_work      o_work
);
    import mpc_pkg::*;

    logic                      r_busy;
    logic                      r_prod_ok;
    logic [IDX_W-1:0]          r_col;
    logic [IDX_W-1:0]          r_row;
    logic signed [COORD_W+11:0] r_px;
    logic signed [COORD_W+11:0] r_py;
    logic signed [COORD_W+12:0] sum_x;
    logic signed [COORD_W+12:0] sum_y;

    function automatic logic signed [COORD_W-1:0] clamp_c(input logic signed [COORD_W+12:0] v);
        logic signed [COORD_W+12:0] hi;
        logic signed [COORD_W+12:0] lo;
        hi = (COORD_W+13)'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    assign sum_x = (COORD_W+13)'(r_px) + (COORD_W+13)'(i_cfg.x_min);
    assign sum_y = (COORD_W+13)'(r_py) + (COORD_W+13)'(i_cfg.y_min);

    assign o_full = r_busy;
    assign o_wr   = r_busy && r_prod_ok && !i_wr_full;
    assign o_work = '{col: r_col, row: r_row, cr: clamp_c(sum_x), ci: clamp_c(sum_y)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_prod_ok <= 1'b0;
        end else if (i_push && !r_busy) begin
            r_busy    <= 1'b1;
            r_prod_ok <= 1'b0;
        end else if (r_busy && !r_prod_ok) begin
            r_prod_ok <= 1'b1;
        end else if (o_wr) begin
            r_busy    <= 1'b0;
            r_prod_ok <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !r_busy) begin
            r_col <= i_req.pixel_col;
            r_row <= i_req.pixel_row;
        end
        if (r_busy && !r_prod_ok) begin
            r_px <= $signed({1'b0, r_col}) * i_cfg.x_step;
            r_py <= $signed({1'b0, r_row}) * i_cfg.y_step;
        end
    end

endmodule

[hdl/mpc_queue.sv]
module mpc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mpc_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output mpc_pkg::t_work o_data
);
    import mpc_pkg::*;

    t_work       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt != 2'd2)) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_cnt != 2'd0)) else $error("queue read while empty");

endmodule

[hdl/mpc_back.sv]
module mpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [mpc_pkg::ITER_W-1:0] i_max_iter,
    input  logic                i_q_empty,
    input  mpc_pkg::t_work      i_work,
    output logic                o_q_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output mpc_pkg::t_pixel_rsp o_rsp
);
    import mpc_pkg::*;

    localparam int LOW_W = ZW + 19;
    localparam int HI_W  = ZW + 18;
    localparam logic [ZW:0] FOUR = (ZW+1)'(4) << FRAC_W;

    t_back_state r_state;
    t_back_state n_state;

    logic [IDX_W-1:0]          r_col;
    logic [IDX_W-1:0]          r_row;
    logic signed [ZW-1:0]      r_cr;
    logic signed [ZW-1:0]      r_ci;
    logic signed [ZW-1:0]      r_x;
    logic signed [ZW-1:0]      r_y;
    logic signed [ZW-1:0]      r_xx;
    logic signed [ZW-1:0]      r_yy;
    logic signed [ZW-1:0]      r_xy;
    logic signed [LOW_W-1:0]   r_lxx;
    logic signed [LOW_W-1:0]   r_lyy;
    logic signed [LOW_W-1:0]   r_lxy;
    logic signed [HI_W-1:0]    r_hxx;
    logic signed [HI_W-1:0]    r_hyy;
    logic signed [HI_W-1:0]    r_hxy;
    logic [CNT_W-1:0]          r_j;
    logic [CNT_W-1:0]          r_count;
    logic                      r_esc;
    logic [23:0]               r_rem;
    logic [7:0]                r_quo;
    logic [2:0]                r_k;
    logic                      r_out_valid;
    t_pixel_rsp                r_out;

    logic       over_limit;
    logic       escaped;
    logic       out_free;
    logic [23:0] div_sub;
    logic       div_ge;

    function automatic logic signed [ZW-1:0] sat_prod(input logic signed [LOW_W-1:0] lo,
                                                      input logic signed [HI_W-1:0] hi);
        logic signed [2*ZW-1:0] full;
        logic signed [2*ZW-FRAC_W-1:0] q;
        full = {{(2*ZW-LOW_W){lo[LOW_W-1]}}, lo} + {hi, 18'b0};
        q = full[2*ZW-1:FRAC_W];
        if (q[2*ZW-FRAC_W-1:ZW-1] == '0 || q[2*ZW-FRAC_W-1:ZW-1] == '1) begin
            return q[ZW-1:0];
        end else if (q[2*ZW-FRAC_W-1]) begin
            return {1'b1, {(ZW-1){1'b0}}};
        end
        return {1'b0, {(ZW-1){1'b1}}};
    endfunction

    function automatic logic signed [ZW-1:0] add_sat(input logic signed [ZW-1:0] a,
                                                     input logic signed [ZW-1:0] b);
        logic signed [ZW:0] s;
        s = {a[ZW-1], a} + {b[ZW-1], b};
        if (s[ZW] != s[ZW-1]) begin
            return s[ZW] ? {1'b1, {(ZW-1){1'b0}}} : {1'b0, {(ZW-1){1'b1}}};
        end
        return s[ZW-1:0];
    endfunction

    function automatic logic [23:0] color(input logic [7:0] hue);
        logic [2:0] s;
        logic [7:0] r;
        logic [9:0] t;
        logic [7:0] up;
        logic [7:0] down;
        case (hue) inside
            [8'd0:8'd59]:    s = 3'd0;
            [8'd60:8'd119]:  s = 3'd1;
            [8'd120:8'd179]: s = 3'd2;
            [8'd180:8'd239]: s = 3'd3;
            default:         s = 3'd4;
        endcase
        r    = hue - 8'(s * 8'd60);
        t    = 10'(r) * 10'd17;
        up   = t[9:2];
        down = 8'd255 - 8'((11'(t) + 11'd3) >> 2);
        case (s)
            3'd0:    return {8'd255, up, 8'd0};
            3'd1:    return {down, 8'd255, 8'd0};
            3'd2:    return {8'd0, 8'd255, up};
            3'd3:    return {8'd0, down, 8'd255};
            default: return {up, 8'd0, 8'd255};
        endcase
    endfunction

    assign over_limit = r_j > {1'b0, i_max_iter};
    assign escaped    = ({1'b0, r_xx} + {1'b0, r_yy}) > FOUR;
    assign out_free   = !r_out_valid || i_pop;
    assign div_sub    = {8'b0, i_max_iter} << r_k;
    assign div_ge     = r_rem >= div_sub;
    assign o_empty    = !r_out_valid;
    assign o_rsp      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_rd  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (over_limit) begin
                    n_state = S_FINISH;
                end else if (escaped) begin
                    n_state = S_DIVIDE;
                end else begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SQUARE;
            S_SQUARE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_TEST;
            S_DIVIDE: begin
                if (r_k == 3'd0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= i_work.col;
                r_row <= i_work.row;
                r_cr  <= ZW'(i_work.cr);
                r_ci  <= ZW'(i_work.ci);
                r_x   <= '0;
                r_y   <= '0;
                r_xx  <= '0;
                r_yy  <= '0;
                r_j   <= CNT_W'(1);
            end
            S_TEST: begin
                if (over_limit) begin
                    r_count <= {1'b0, i_max_iter} + CNT_W'(1);
                    r_esc   <= 1'b0;
                end else if (escaped) begin
                    r_count <= r_j;
                    r_esc   <= 1'b1;
                    r_rem   <= 24'(r_j) * 24'd255;
                    r_quo   <= '0;
                    r_k     <= 3'd7;
                end
            end
            S_MUL_LO: begin
                r_lxx <= r_x * $signed({1'b0, r_x[17:0]});
                r_lyy <= r_y * $signed({1'b0, r_y[17:0]});
                r_lxy <= r_x * $signed({1'b0, r_y[17:0]});
            end
            S_MUL_HI: begin
                r_hxx <= r_x * $signed(r_x[ZW-1:18]);
                r_hyy <= r_y * $signed(r_y[ZW-1:18]);
                r_hxy <= r_x * $signed(r_y[ZW-1:18]);
            end
            S_SQUARE: begin
                r_xx <= sat_prod(r_lxx, r_hxx);
                r_yy <= sat_prod(r_lyy, r_hyy);
                r_xy <= sat_prod(r_lxy, r_hxy);
            end
            S_UPDATE: begin
                r_x <= add_sat(add_sat(r_xx, -r_yy), r_cr);
                r_y <= add_sat(add_sat(r_xy, r_xy), r_ci);
                r_j <= r_j + CNT_W'(1);
            end
            S_DIVIDE: begin
                if (div_ge) begin
                    r_rem      <= r_rem - div_sub;
                    r_quo[r_k] <= 1'b1;
                end
                r_k <= r_k - 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_out.out_col    <= r_col;
            r_out.out_row    <= r_row;
            r_out.iter_count <= r_count;
            {r_out.red, r_out.green, r_out.blue} <= r_esc ? color(r_quo) : 24'd0;
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result changed before it was taken");
    a_divide_escaped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |-> (r_esc && r_count <= {1'b0, i_max_iter}))
        else $error("hue division entered for an interior pixel");

endmodule

[hdl/mandelbrot_pixel_colorizer.sv]
// Channel    Direction  Handshake               Payload
// request    in         push / full             i_req  (pixel_col, pixel_row)
// result     out        empty / pop             o_rsp  (out_col .. iter_count)
// config     in         i_cfg_valid / ready     i_cfg_index, i_cfg_data
//
// The front registers the pixel indices, then the step products, and passes c
// through a two-entry queue. The back steps through S_TEST, S_MUL_LO, S_MUL_HI,
// S_SQUARE and S_UPDATE per escape-time iteration, with the squaring multipliers split
// into low and high halves, then divides out the hue bit by bit for an escaped pixel.
// Reset is synchronous and active low; the config registers return to defaults.
// A waiting result stalls the back; new requests are taken until the queue and front fill.
module mandelbrot_pixel_colorizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mpc_pkg::t_pixel_req i_req,
    output logic                empty,
    input  logic                pop,
    output mpc_pkg::t_pixel_rsp o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [mpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mpc_pkg::COORD_W-1:0]   i_cfg_data
);
    import mpc_pkg::*;

    t_cfg  r_cfg;
    t_work wr_data;
    t_work rd_data;
    logic  wr;
    logic  wr_full;
    logic  rd;
    logic  q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{x_min: RST_X_MIN, x_step: RST_X_STEP, y_min: RST_Y_MIN,
                       y_step: RST_Y_STEP, max_iter: RST_MAX_ITER};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_MIN:    r_cfg.x_min    <= i_cfg_data;
                CFG_X_STEP:   r_cfg.x_step   <= i_cfg_data;
                CFG_Y_MIN:    r_cfg.y_min    <= i_cfg_data;
                CFG_Y_STEP:   r_cfg.y_step   <= i_cfg_data;
                CFG_MAX_ITER: r_cfg.max_iter <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_req     (i_req),
        .i_cfg     (r_cfg),
        .o_wr      (wr),
        .i_wr_full (wr_full),
        .o_work    (wr_data)
    );

    mpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_data  (wr_data),
        .o_full  (wr_full),
        .i_rd    (rd),
        .o_empty (q_empty),
        .o_data  (rd_data)
    );

    mpc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_iter (r_cfg.max_iter),
        .i_q_empty  (q_empty),
        .i_work     (rd_data),
        .o_q_rd     (rd),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule

[test/mandelbrot_pixel_colorizer_test.sv]
module mandelbrot_pixel_colorizer_test;
    import mpc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam longint FOUR_Q = 64'sd4 <<< FRAC_W;

    typedef enum logic {ROW_CFG, ROW_PIXEL} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   data;
        t_pixel_req           req;
        bit                   typed;
        t_pixel_rsp           rsp;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_pixel_req           i_req = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_pixel_rsp           o_rsp;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;

    t_cfg       win;
    t_pixel_rsp pending_pixels[$];
    t_row       rows[$];
    int         errors = 0;
    int         cycles = 0;
    int         pixels_out = 0;
    int         pop_wait = 0;
    int         hold_left = 0;

    mandelbrot_pixel_colorizer u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mandelbrot_pixel_colorizer_test: errors");
            $finish;
        end
    end

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        logic signed [127:0] hi;
        pa = a;
        pb = b;
        p = (pa * pb) >>> FRAC_W;
        hi = (128'sd1 <<< (ZW - 1)) - 1;
        if (p > hi) return longint'(hi);
        if (p < -hi - 1) return longint'(-hi - 1);
        return longint'(p);
    endfunction

    function automatic t_pixel_rsp color_pixel(t_pixel_req r);
        t_pixel_rsp res;
        longint cr, ci, x, y, xx, yy, xy;
        int unsigned count, hue, sector, rem, up, down;
        x = 0;
        y = 0;
        xx = 0;
        yy = 0;
        cr = clamp_bits(longint'(win.x_min) + longint'(r.pixel_col) * longint'(win.x_step),
                        COORD_W);
        ci = clamp_bits(longint'(win.y_min) + longint'(r.pixel_row) * longint'(win.y_step),
                        COORD_W);
        count = win.max_iter + 1;
        for (int unsigned j = 1; j <= win.max_iter; j++) begin
            if (xx + yy > FOUR_Q) begin
                count = j;
                break;
            end
            xy = fix_mul(x, y);
            xx = fix_mul(x, x);
            yy = fix_mul(y, y);
            x = clamp_bits(clamp_bits(xx - yy, ZW) + cr, ZW);
            y = clamp_bits(clamp_bits(xy + xy, ZW) + ci, ZW);
        end
        res = '0;
        res.out_col = r.pixel_col;
        res.out_row = r.pixel_row;
        res.iter_count = count[CNT_W-1:0];
        if (count <= win.max_iter) begin
            hue = (255 * count) / win.max_iter;
            sector = hue / 60;
            rem = hue % 60;
            up = (17 * rem) / 4;
            down = 255 - (17 * rem + 3) / 4;
            case (sector)
                0: begin res.red = 255; res.green = up[7:0]; res.blue = 0; end
                1: begin res.red = down[7:0]; res.green = 255; res.blue = 0; end
                2: begin res.red = 0; res.green = 255; res.blue = up[7:0]; end
                3: begin res.red = 0; res.green = down[7:0]; res.blue = 255; end
                4: begin res.red = up[7:0]; res.green = 0; res.blue = 255; end
                default: begin res.red = 255; res.green = 0; res.blue = down[7:0]; end
            endcase
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_rsp want;
        logic next_pop;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel col=%0d row=%0d", o_rsp.out_col, o_rsp.out_row);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_rsp.out_col !== want.out_col) begin
                    $error("out_col expected %0d got %0d", want.out_col, o_rsp.out_col);
                    errors++;
                end
                if (o_rsp.out_row !== want.out_row) begin
                    $error("out_row expected %0d got %0d", want.out_row, o_rsp.out_row);
                    errors++;
                end
                if (o_rsp.red !== want.red) begin
                    $error("red expected %0d got %0d", want.red, o_rsp.red);
                    errors++;
                end
                if (o_rsp.green !== want.green) begin
                    $error("green expected %0d got %0d", want.green, o_rsp.green);
                    errors++;
                end
                if (o_rsp.blue !== want.blue) begin
                    $error("blue expected %0d got %0d", want.blue, o_rsp.blue);
                    errors++;
                end
                if (o_rsp.iter_count !== want.iter_count) begin
                    $error("iter_count expected %0d got %0d", want.iter_count,
                           o_rsp.iter_count);
                    errors++;
                end
            end
            pixels_out++;
            pop_wait = (pixels_out % 200 < 40) ? 0 : $urandom_range(0, 3);
            if (pixels_out == 300) hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_pop = 1'b0;
        end else if (pop_wait > 0) begin
            pop_wait--;
            next_pop = 1'b0;
        end else begin
            next_pop = i_rst_n;
        end
        pop <= next_pop;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_X_MIN:    win.x_min = data;
            CFG_X_STEP:   win.x_step = data;
            CFG_Y_MIN:    win.y_min = data;
            CFG_Y_STEP:   win.y_step = data;
            CFG_MAX_ITER: win.max_iter = data[ITER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(t_pixel_req r, bit typed, t_pixel_rsp rsp, bit busy);
        int gap;
        i_cfg_valid <= 1'b0;
        gap = busy ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        pending_pixels.push_back(typed ? rsp : color_pixel(r));
    endtask

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        t_row r;
        r = '{ROW_CFG, idx, data, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row pix_row(int c, int rw, bit typed, t_pixel_rsp rsp);
        t_row r;
        r = '{ROW_PIXEL, CFG_X_MIN, '0, '{c[IDX_W-1:0], rw[IDX_W-1:0]}, typed, rsp};
        return r;
    endfunction

    initial begin
        t_pixel_req r;
        logic [COORD_W-1:0] xs, ys;
        win = '{RST_X_MIN, RST_X_STEP, RST_Y_MIN, RST_Y_STEP, RST_MAX_ITER};

        rows.push_back(pix_row(0, 0, 0, '0));
        rows.push_back(pix_row(2047, 2047, 0, '0));
        rows.push_back(pix_row(0, 2047, 0, '0));
        rows.push_back(pix_row(2047, 0, 0, '0));
        rows.push_back(pix_row(1100, 900, 0, '0));
        rows.push_back(pix_row(1365, 682, 0, '0));
        rows.push_back(cfg_row(CFG_X_MIN, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(CFG_X_STEP, '0));
        rows.push_back(cfg_row(CFG_Y_MIN, '0));
        rows.push_back(cfg_row(CFG_Y_STEP, '0));
        rows.push_back(cfg_row(CFG_MAX_ITER, 32'd2));
        rows.push_back(pix_row(5, 5, 1, '{11'd5, 11'd5, 8'd0, 8'd0, 8'd0, 17'd3}));
        rows.push_back(cfg_row(CFG_MAX_ITER, 32'd1));
        rows.push_back(pix_row(7, 9, 1, '{11'd7, 11'd9, 8'd0, 8'd0, 8'd0, 17'd2}));
        rows.push_back(cfg_row(CFG_MAX_ITER, 32'd0));
        rows.push_back(pix_row(2047, 1, 1, '{11'd2047, 11'd1, 8'd0, 8'd0, 8'd0, 17'd1}));
        rows.push_back(cfg_row(CFG_MAX_ITER, 32'hFFFF_FFFF));
        rows.push_back(pix_row(3, 4, 1, '{11'd3, 11'd4, 8'd255, 8'd0, 8'd0, 17'd3}));
        rows.push_back(cfg_row(CFG_X_MIN, 32'h8000_0000));
        rows.push_back(cfg_row(CFG_MAX_ITER, 32'd3));
        rows.push_back(pix_row(0, 0, 0, '0));
        rows.push_back(cfg_row(CFG_X_STEP, 32'h7FFF_FFFF));
        rows.push_back(cfg_row(CFG_Y_STEP, 32'h8000_0000));
        rows.push_back(pix_row(2047, 2047, 0, '0));
        rows.push_back(pix_row(1, 1, 0, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                write_reg(rows[k].idx, rows[k].data);
            end else begin
                send_pixel(rows[k].req, rows[k].typed, rows[k].rsp, 1'b0);
            end
        end

        for (int phase = 0; phase < 14; phase++) begin
            if (phase % 4 == 3) begin
                write_reg(CFG_X_MIN, $urandom);
                write_reg(CFG_X_STEP, $urandom);
                write_reg(CFG_Y_MIN, $urandom);
                write_reg(CFG_Y_STEP, $urandom);
            end else begin
                xs = $urandom_range(0, 400000);
                ys = $urandom_range(0, 400000);
                write_reg(CFG_X_MIN, -32'sd671088640 + 32'($urandom_range(0, 500000000)));
                write_reg(CFG_X_STEP, $urandom_range(0, 1) ? xs : -xs);
                write_reg(CFG_Y_MIN, -32'sd402653184 + 32'($urandom_range(0, 400000000)));
                write_reg(CFG_Y_STEP, $urandom_range(0, 1) ? ys : -ys);
            end
            write_reg(CFG_MAX_ITER, (phase % 5 == 2) ? $urandom_range(100, 255)
                                                     : $urandom_range(1, 40));
            for (int n = 0; n < 100; n++) begin
                r.pixel_col = $urandom_range(0, 2047);
                r.pixel_row = $urandom_range(0, 2047);
                send_pixel(r, 1'b0, '0, phase == 1 || phase == 6);
            end
        end

        write_reg(CFG_X_MIN, 32'h7F00_0000 + 32'($urandom_range(0, 1000)));
        write_reg(CFG_X_STEP, $urandom_range(0, 100));
        write_reg(CFG_MAX_ITER, 32'd65535);
        for (int n = 0; n < 6; n++) begin
            r.pixel_col = $urandom_range(0, 2047);
            r.pixel_row = $urandom_range(0, 2047);
            send_pixel(r, 1'b0, '0, 1'b0);
        end
        push <= 1'b0;
        i_cfg_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("mandelbrot_pixel_colorizer_test: clean");
        end else begin
            $display("mandelbrot_pixel_colorizer_test: errors");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/mpc_pkg.sv
hdl/mpc_front.sv
hdl/mpc_queue.sv
hdl/mpc_back.sv
hdl/mandelbrot_pixel_colorizer.sv
test/mandelbrot_pixel_colorizer_test.sv
